FILE: src/gsc_pkg.sv
// ============================================================================
// gsc_pkg: shared types and microcode for the grid sparsity checker
// Holds field widths, request and register codes, the control word format
// and the microprogram that sequences every request.
// ============================================================================
`default_nettype none

package gsc_pkg;

    localparam int CRD_W      = 4;   // coordinate field width
    localparam int REQ_W      = 2;
    localparam int ST_W       = 2;   // cell state width
    localparam int SP_W       = 4;   // sparsity register width
    localparam int SZ_W       = 5;   // grid size register width
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 5;
    localparam int BND_W      = 8;   // signed box bound width
    localparam int SQ_W       = 8;   // one squared offset, or sparsity squared
    localparam int DIST_W     = 10;  // sum of three squared offsets
    localparam int UPC_W      = 4;

    typedef logic [REQ_W-1:0]        t_req;
    typedef logic [ST_W-1:0]         t_state;
    typedef logic [CFG_IDX_W-1:0]    t_cfg_idx;
    typedef logic signed [BND_W-1:0] t_bnd;
    typedef logic [UPC_W-1:0]        t_upc;

    localparam t_req REQ_WRITE = 2'd0;
    localparam t_req REQ_READ  = 2'd1;
    localparam t_req REQ_QUERY = 2'd2;

    localparam t_state ST_UNINIT  = 2'd0;
    localparam t_state ST_PASSAGE = 2'd1;

    localparam t_cfg_idx CFG_SPARSITY = 2'd0;
    localparam t_cfg_idx CFG_WIDTH    = 2'd1;
    localparam t_cfg_idx CFG_HEIGHT   = 2'd2;
    localparam t_cfg_idx CFG_DEPTH    = 2'd3;

    // Datapath operation selected by one control word.
    typedef enum logic [3:0] {
        UOP_NOP,
        UOP_CLEAR,
        UOP_ACCEPT,
        UOP_WRITE,
        UOP_READ,
        UOP_RDCAP,
        UOP_BOUNDS,
        UOP_INIT,
        UOP_SCAN,
        UOP_EMIT
    } t_uop;

    // Jump condition of one control word.
    typedef enum logic [3:0] {
        UC_NEVER,
        UC_ALWAYS,
        UC_NO_IN,
        UC_CLR_MORE,
        UC_IS_WR,
        UC_IS_RD,
        UC_IS_QRY,
        UC_NO_CHECK,
        UC_EMPTY,
        UC_LOOP,
        UC_OUT_BUSY
    } t_ucond;

    typedef struct packed {
        t_uop   op;
        t_ucond cond;
        t_upc   tgt;
    } t_uword;

    // Status that the datapath hands to the sequencer for its jumps.
    typedef struct packed {
        logic in_valid;
        logic out_busy;
        logic clr_more;
        logic is_wr;
        logic is_rd;
        logic is_qry;
        logic no_check;
        logic empty;
        logic loop;
    } t_flags;

    // Microprogram entry points.
    localparam t_upc U_CLR  = 4'd0;
    localparam t_upc U_IDLE = 4'd1;
    localparam t_upc U_DSP0 = 4'd2;
    localparam t_upc U_DSP1 = 4'd3;
    localparam t_upc U_DSP2 = 4'd4;
    localparam t_upc U_NOOP = 4'd5;
    localparam t_upc U_WR   = 4'd6;
    localparam t_upc U_RD   = 4'd7;
    localparam t_upc U_RDC  = 4'd8;
    localparam t_upc U_BOX  = 4'd9;
    localparam t_upc U_INIT = 4'd10;
    localparam t_upc U_SCAN = 4'd11;
    localparam t_upc U_EMIT = 4'd12;
    localparam t_upc U_RET  = 4'd13;

    // The control store. A word jumps to tgt when its condition holds and
    // otherwise falls through to the next step.
    function automatic t_uword ucode_rom(input t_upc pc);
        t_uword w;
        case (pc)
            U_CLR:   w = '{UOP_CLEAR,  UC_CLR_MORE, U_CLR};
            U_IDLE:  w = '{UOP_ACCEPT, UC_NO_IN,    U_IDLE};
            U_DSP0:  w = '{UOP_NOP,    UC_IS_WR,    U_WR};
            U_DSP1:  w = '{UOP_NOP,    UC_IS_RD,    U_RD};
            U_DSP2:  w = '{UOP_NOP,    UC_IS_QRY,   U_BOX};
            U_NOOP:  w = '{UOP_NOP,    UC_ALWAYS,   U_EMIT};
            U_WR:    w = '{UOP_WRITE,  UC_ALWAYS,   U_EMIT};
            U_RD:    w = '{UOP_READ,   UC_NEVER,    U_RDC};
            U_RDC:   w = '{UOP_RDCAP,  UC_ALWAYS,   U_EMIT};
            U_BOX:   w = '{UOP_BOUNDS, UC_NO_CHECK, U_EMIT};
            U_INIT:  w = '{UOP_INIT,   UC_EMPTY,    U_EMIT};
            U_SCAN:  w = '{UOP_SCAN,   UC_LOOP,     U_SCAN};
            U_EMIT:  w = '{UOP_EMIT,   UC_OUT_BUSY, U_EMIT};
            U_RET:   w = '{UOP_NOP,    UC_ALWAYS,   U_IDLE};
            default: w = '{UOP_NOP,    UC_ALWAYS,   U_IDLE};
        endcase
        return w;
    endfunction

    // Distance between two small unsigned coordinates; callers keep it
    // below sixteen.
    function automatic logic [CRD_W-1:0] abs_diff(input logic [BND_W-1:0] a,
                                                  input logic [BND_W-1:0] b);
        logic [BND_W-1:0] d;
        d = (a >= b) ? (a - b) : (b - a);
        return d[CRD_W-1:0];
    endfunction

endpackage

`default_nettype wire

FILE: src/gsc_ram.sv
// ============================================================================
// gsc_ram: generic single-write, single-read RAM
// One write port and one read port, read data registered.
// ============================================================================
`default_nettype none

module gsc_ram #(
    parameter int WIDTH = 2,
    parameter int DEPTH = 4096
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  wire logic [WIDTH-1:0]         i_wr_data,
    input  wire logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic      [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        o_rd_data <= r_mem[i_rd_addr];
    end

endmodule

`default_nettype wire

FILE: src/gsc_seq.sv
// ============================================================================
// gsc_seq: microprogram sequencer
// Step counter, control store fetch and conditional jump selection.
// ============================================================================
`default_nettype none

module gsc_seq
    import gsc_pkg::*;
(
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    input  wire t_flags i_flags,
    output t_uop        o_op
);

    t_upc   r_pc;
    t_upc   n_pc;
    t_uword uword;
    logic   take;

    assign uword = ucode_rom(r_pc);
    assign o_op  = uword.op;

    always_comb begin
        unique case (uword.cond)
            UC_NEVER:    take = 1'b0;
            UC_ALWAYS:   take = 1'b1;
            UC_NO_IN:    take = !i_flags.in_valid;
            UC_CLR_MORE: take = i_flags.clr_more;
            UC_IS_WR:    take = i_flags.is_wr;
            UC_IS_RD:    take = i_flags.is_rd;
            UC_IS_QRY:   take = i_flags.is_qry;
            UC_NO_CHECK: take = i_flags.no_check;
            UC_EMPTY:    take = i_flags.empty;
            UC_LOOP:     take = i_flags.loop;
            UC_OUT_BUSY: take = i_flags.out_busy;
            default:     take = 1'b1;
        endcase
        n_pc = take ? uword.tgt : r_pc + t_upc'(1);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc <= U_CLR;
        end else begin
            r_pc <= n_pc;
        end
    end

endmodule

`default_nettype wire

FILE: src/gsc_dp.sv
// ============================================================================
// gsc_dp: datapath of the grid sparsity checker
// Configuration registers, request capture, box bound arithmetic, scan
// counters with a one-deep read pipeline, and the output register.
// ============================================================================
`default_nettype none

module gsc_dp
    import gsc_pkg::*;
#(
    parameter int GRID_SIDE    = 16,
    parameter int MAX_SPARSITY = 8,
    parameter int CW           = $clog2(GRID_SIDE),
    parameter int AW           = 3 * CW
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire t_uop                  i_op,
    output t_flags                     o_flags,
    // configuration
    input  wire logic                  i_cfg_wr_en,
    input  wire t_cfg_idx              i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_wdata,
    // input channel
    input  wire logic                  i_in_valid,
    output logic                       o_in_stall,
    input  wire t_req                  i_req_type,
    input  wire logic [CRD_W-1:0]      i_cell_x,
    input  wire logic [CRD_W-1:0]      i_cell_y,
    input  wire logic [CRD_W-1:0]      i_cell_z,
    input  wire logic [CRD_W-1:0]      i_from_x,
    input  wire logic [CRD_W-1:0]      i_from_y,
    input  wire logic [CRD_W-1:0]      i_from_z,
    input  wire t_state                i_new_state,
    // output channel
    output logic                       o_out_valid,
    input  wire logic                  i_out_stall,
    output t_state                     o_read_state,
    output logic                       o_passable,
    // grid memory
    output logic                       o_ram_wr_en,
    output logic [AW-1:0]              o_ram_wr_addr,
    output t_state                     o_ram_wr_data,
    output logic [AW-1:0]              o_ram_rd_addr,
    input  wire t_state                i_ram_rd_data
);

    logic [SP_W-1:0]  r_sparsity;
    logic [SZ_W-1:0]  r_gw, r_gh, r_gd;

    t_req             r_req;
    logic [CRD_W-1:0] r_x, r_y, r_z, r_fx, r_fy, r_fz;
    t_state           r_nstate;
    logic             r_in_store;

    logic [AW-1:0]    r_clr_addr;

    t_bnd             r_il, r_iu, r_jl, r_ju, r_kl, r_ku;
    logic [SQ_W-1:0]  r_s2;
    logic [CW-1:0]    r_i, r_j, r_k;
    logic             r_scan_done;
    logic             r_p1_valid;
    logic [DIST_W-1:0] r_p1_dist;

    t_state           r_rstate;
    logic             r_pass;
    logic             r_o_valid;
    t_state           r_o_state;
    logic             r_o_pass;

    logic [SP_W-1:0]  s_eff;
    logic             no_check;
    t_bnd             n_il, n_iu, n_jl, n_ju, n_kl, n_ku;
    logic             box_empty;
    logic [CRD_W-1:0] ex, ey, ez;
    logic [DIST_W-1:0] n_dist;
    logic             i_last, j_last, k_last, cell_last;
    logic             hit;
    logic [CW-1:0]    cx, cy, cz;

    // Box around the target, cut to the half ahead of the move and clipped
    // to the configured grid size.
    always_comb begin
        t_bnd sm1;
        t_bnd bx, by, bz;
        t_bnd wm1, hm1, dm1;
        logic [SZ_W-1:0] w, h, d;

        if (int'(r_sparsity) > MAX_SPARSITY) begin
            s_eff = SP_W'(MAX_SPARSITY);
        end else begin
            s_eff = r_sparsity;
        end
        no_check = (s_eff <= SP_W'(1));

        w = (int'(r_gw) > GRID_SIDE) ? SZ_W'(GRID_SIDE) : r_gw;
        h = (int'(r_gh) > GRID_SIDE) ? SZ_W'(GRID_SIDE) : r_gh;
        d = (int'(r_gd) > GRID_SIDE) ? SZ_W'(GRID_SIDE) : r_gd;
        wm1 = t_bnd'({3'd0, w}) - t_bnd'(1);
        hm1 = t_bnd'({3'd0, h}) - t_bnd'(1);
        dm1 = t_bnd'({3'd0, d}) - t_bnd'(1);

        sm1 = t_bnd'({4'd0, s_eff}) - t_bnd'(1);
        bx  = t_bnd'({4'd0, r_x});
        by  = t_bnd'({4'd0, r_y});
        bz  = t_bnd'({4'd0, r_z});

        n_il = bx - sm1;
        n_iu = bx + sm1;
        n_jl = by - sm1;
        n_ju = by + sm1;
        n_kl = bz - sm1;
        n_ku = bz + sm1;

        // The first axis that moved picks the cut; no move at all cuts -z.
        if (r_x > r_fx) begin
            n_il = bx;
        end else if (r_x < r_fx) begin
            n_iu = bx;
        end else if (r_y > r_fy) begin
            n_jl = by;
        end else if (r_y < r_fy) begin
            n_ju = by;
        end else if (r_z > r_fz) begin
            n_kl = bz;
        end else begin
            n_ku = bz;
        end

        if (n_il < t_bnd'(0)) n_il = t_bnd'(0);
        if (n_jl < t_bnd'(0)) n_jl = t_bnd'(0);
        if (n_kl < t_bnd'(0)) n_kl = t_bnd'(0);
        if (n_iu > wm1) n_iu = wm1;
        if (n_ju > hm1) n_ju = hm1;
        if (n_ku > dm1) n_ku = dm1;
    end

    assign box_empty = (r_il > r_iu) || (r_jl > r_ju) || (r_kl > r_ku);

    // Squared distance of the cell under the scan counters.
    assign ex = abs_diff(BND_W'(r_i), BND_W'(r_x));
    assign ey = abs_diff(BND_W'(r_j), BND_W'(r_y));
    assign ez = abs_diff(BND_W'(r_k), BND_W'(r_z));
    assign n_dist = DIST_W'(SQ_W'(ex) * SQ_W'(ex))
                  + DIST_W'(SQ_W'(ey) * SQ_W'(ey))
                  + DIST_W'(SQ_W'(ez) * SQ_W'(ez));

    assign i_last    = (r_i == r_iu[CW-1:0]);
    assign j_last    = (r_j == r_ju[CW-1:0]);
    assign k_last    = (r_k == r_ku[CW-1:0]);
    assign cell_last = i_last && j_last && k_last;

    // The word read in the previous scan step is checked against its distance.
    assign hit = r_p1_valid && (i_ram_rd_data == ST_PASSAGE)
              && (r_p1_dist < DIST_W'(r_s2));

    assign cx = CW'(r_x);
    assign cy = CW'(r_y);
    assign cz = CW'(r_z);

    assign o_ram_wr_en   = (i_op == UOP_CLEAR) || ((i_op == UOP_WRITE) && r_in_store);
    assign o_ram_wr_addr = (i_op == UOP_CLEAR) ? r_clr_addr : {cx, cy, cz};
    assign o_ram_wr_data = (i_op == UOP_CLEAR) ? ST_UNINIT : r_nstate;
    assign o_ram_rd_addr = (i_op == UOP_READ) ? {cx, cy, cz} : {r_i, r_j, r_k};

    assign o_in_stall   = (i_op != UOP_ACCEPT);
    assign o_out_valid  = r_o_valid;
    assign o_read_state = r_o_state;
    assign o_passable   = r_o_pass;

    assign o_flags.in_valid = i_in_valid;
    assign o_flags.out_busy = r_o_valid && i_out_stall;
    assign o_flags.clr_more = (r_clr_addr != '1);
    assign o_flags.is_wr    = (r_req == REQ_WRITE);
    assign o_flags.is_rd    = (r_req == REQ_READ);
    assign o_flags.is_qry   = (r_req == REQ_QUERY);
    assign o_flags.no_check = no_check;
    assign o_flags.empty    = box_empty;
    assign o_flags.loop     = !hit && !r_scan_done;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sparsity  <= SP_W'(2);
            r_gw        <= SZ_W'(16);
            r_gh        <= SZ_W'(16);
            r_gd        <= SZ_W'(16);
            r_clr_addr  <= '0;
            r_scan_done <= 1'b0;
            r_p1_valid  <= 1'b0;
            r_o_valid   <= 1'b0;
            r_rstate    <= ST_UNINIT;
            r_pass      <= 1'b0;
            r_req       <= REQ_WRITE;
        end else begin
            if (i_cfg_wr_en) begin
                unique case (i_cfg_index)
                    CFG_SPARSITY: r_sparsity <= i_cfg_wdata[SP_W-1:0];
                    CFG_WIDTH:    r_gw       <= i_cfg_wdata[SZ_W-1:0];
                    CFG_HEIGHT:   r_gh       <= i_cfg_wdata[SZ_W-1:0];
                    CFG_DEPTH:    r_gd       <= i_cfg_wdata[SZ_W-1:0];
                    default: ;
                endcase
            end

            if (r_o_valid && !i_out_stall && (i_op != UOP_EMIT)) begin
                r_o_valid <= 1'b0;
            end

            unique case (i_op)
                UOP_CLEAR: begin
                    r_clr_addr <= r_clr_addr + AW'(1);
                end
                UOP_ACCEPT: begin
                    if (i_in_valid) begin
                        r_req      <= i_req_type;
                        r_x        <= i_cell_x;
                        r_y        <= i_cell_y;
                        r_z        <= i_cell_z;
                        r_fx       <= i_from_x;
                        r_fy       <= i_from_y;
                        r_fz       <= i_from_z;
                        r_nstate   <= i_new_state;
                        r_in_store <= (int'(i_cell_x) < GRID_SIDE)
                                   && (int'(i_cell_y) < GRID_SIDE)
                                   && (int'(i_cell_z) < GRID_SIDE);
                        r_rstate   <= ST_UNINIT;
                        r_pass     <= 1'b0;
                    end
                end
                UOP_RDCAP: begin
                    r_rstate <= r_in_store ? i_ram_rd_data : ST_UNINIT;
                end
                UOP_BOUNDS: begin
                    r_il   <= n_il;
                    r_iu   <= n_iu;
                    r_jl   <= n_jl;
                    r_ju   <= n_ju;
                    r_kl   <= n_kl;
                    r_ku   <= n_ku;
                    r_s2   <= SQ_W'(s_eff) * SQ_W'(s_eff);
                    r_pass <= 1'b1;
                end
                UOP_INIT: begin
                    r_i         <= r_il[CW-1:0];
                    r_j         <= r_jl[CW-1:0];
                    r_k         <= r_kl[CW-1:0];
                    r_scan_done <= 1'b0;
                    r_p1_valid  <= 1'b0;
                end
                UOP_SCAN: begin
                    if (hit) begin
                        r_pass <= 1'b0;
                    end
                    if (!r_scan_done) begin
                        r_p1_valid <= 1'b1;
                        r_p1_dist  <= n_dist;
                        if (cell_last) begin
                            r_scan_done <= 1'b1;
                        end
                        if (k_last) begin
                            r_k <= r_kl[CW-1:0];
                            if (j_last) begin
                                r_j <= r_jl[CW-1:0];
                                r_i <= r_i + CW'(1);
                            end else begin
                                r_j <= r_j + CW'(1);
                            end
                        end else begin
                            r_k <= r_k + CW'(1);
                        end
                    end else begin
                        r_p1_valid <= 1'b0;
                    end
                end
                UOP_EMIT: begin
                    if (!r_o_valid || !i_out_stall) begin
                        r_o_valid <= 1'b1;
                        r_o_state <= r_rstate;
                        r_o_pass  <= r_pass;
                    end
                end
                default: ;
            endcase
        end
    end

endmodule

`default_nettype wire

FILE: src/grid_sparsity_check_core.sv
// ============================================================================
// grid_sparsity_check_core: passage spacing checker over a 3D cell grid
// Stores 2-bit cell states and answers write, read and passability requests.
// ============================================================================
// After reset the block clears all 2^(3*ceil(log2(GRID_SIDE))) grid cells
// (4096 at the default size), one cell per cycle; input stall stays high
// during that pass, while configuration writes are taken at any time.
// Requests are handled one at a time by a microcoded sequencer. A write
// registers its result word after the grid write and a read after the grid
// read and its capture; the sequencer then passes a return step before the
// next request can be accepted. A query registers its result once the scan
// of its clipped box ends; the grid memory has one read port and the scan
// reads one cell per cycle, and it stops at the first passage found too
// close. A query with an effective sparsity of 1 or less, or whose box is
// empty, skips the scan. The box holds at most (2s-1)*(2s-1)*s cells for
// an effective sparsity s, 1800 at MAX_SPARSITY of 8. A finished result
// word sits in an output register, and the next request is accepted while
// it waits to be taken; a result that finds that register still occupied
// waits for it, adding the output stall to the item's time.
// ============================================================================
`default_nettype none

module grid_sparsity_check_core
    import gsc_pkg::*;
#(
    parameter int GRID_SIDE    = 16,
    parameter int MAX_SPARSITY = 8
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    // configuration
    input  wire logic                  i_cfg_wr_en,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_wdata,
    // request words
    input  wire logic                  i_in_valid,
    output logic                       o_in_stall,
    input  wire logic [REQ_W-1:0]      i_req_type,
    input  wire logic [CRD_W-1:0]      i_cell_x,
    input  wire logic [CRD_W-1:0]      i_cell_y,
    input  wire logic [CRD_W-1:0]      i_cell_z,
    input  wire logic [CRD_W-1:0]      i_from_x,
    input  wire logic [CRD_W-1:0]      i_from_y,
    input  wire logic [CRD_W-1:0]      i_from_z,
    input  wire logic [ST_W-1:0]       i_new_state,
    // result words
    output logic                       o_out_valid,
    input  wire logic                  i_out_stall,
    output logic [ST_W-1:0]            o_read_state,
    output logic                       o_passable
);

    localparam int CW    = $clog2(GRID_SIDE);
    localparam int AW    = 3 * CW;
    localparam int DEPTH = 1 << AW;

    t_uop          op;
    t_flags        flags;
    logic          ram_wr_en;
    logic [AW-1:0] ram_wr_addr;
    t_state        ram_wr_data;
    logic [AW-1:0] ram_rd_addr;
    t_state        ram_rd_data;

    gsc_seq u_seq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_flags (flags),
        .o_op    (op)
    );

    gsc_dp #(
        .GRID_SIDE    (GRID_SIDE),
        .MAX_SPARSITY (MAX_SPARSITY),
        .CW           (CW),
        .AW           (AW)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_op          (op),
        .o_flags       (flags),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_wdata   (i_cfg_wdata),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_req_type    (i_req_type),
        .i_cell_x      (i_cell_x),
        .i_cell_y      (i_cell_y),
        .i_cell_z      (i_cell_z),
        .i_from_x      (i_from_x),
        .i_from_y      (i_from_y),
        .i_from_z      (i_from_z),
        .i_new_state   (i_new_state),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_read_state  (o_read_state),
        .o_passable    (o_passable),
        .o_ram_wr_en   (ram_wr_en),
        .o_ram_wr_addr (ram_wr_addr),
        .o_ram_wr_data (ram_wr_data),
        .o_ram_rd_addr (ram_rd_addr),
        .i_ram_rd_data (ram_rd_data)
    );

    gsc_ram #(
        .WIDTH (ST_W),
        .DEPTH (DEPTH)
    ) u_grid (
        .i_clk     (i_clk),
        .i_wr_en   (ram_wr_en),
        .i_wr_addr (ram_wr_addr),
        .i_wr_data (ram_wr_data),
        .i_rd_addr (ram_rd_addr),
        .o_rd_data (ram_rd_data)
    );

endmodule

`default_nettype wire
